### hdl/dltq_pkg.sv
`timescale 1ns / 1ps

package dltq_pkg;

  localparam int TABLE_SLOTS_DEF = 32;

  localparam int KIND_W   = 1;
  localparam int HANDLE_W = 16;
  localparam int DELTA_W  = 15;
  localparam int STATUS_W = 2;
  localparam int ENTRY_W  = DELTA_W + HANDLE_W;

  localparam logic KIND_TICK   = 1'b0;
  localparam logic KIND_INSERT = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_INSERTED = 2'd0,
    ST_EXPIRED  = 2'd1,
    ST_FULL     = 2'd2
  } status_t;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_WALK  = 7'b0000010,
    S_PLACE = 7'b0000100,
    S_SCAN  = 7'b0001000,
    S_ERD   = 7'b0010000,
    S_EOUT  = 7'b0100000,
    S_RESP  = 7'b1000000
  } state_t;

endpackage

### hdl/dltq_ram.sv
`timescale 1ns / 1ps

module dltq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hdl/delta_list_timer_queue_unit.sv
`timescale 1ns / 1ps
// delta list timer queue
// input channel (in_valid/in_ready): in_kind selects a tick or an insert; an insert
// carries in_handle and in_delay, a tick carries in_blocked.
// result channel (out_valid/out_ready): out_status, out_fired_handle, out_last.
// an insert gives one result (inserted or table full); a tick gives one result per
// expired entry, the final one marked with out_last, or none at all.
// entries live in one ram with a circular head pointer and a registered read port;
// walk and scan read one entry per cycle; an expired entry is read again to send it.
// insert: walks past p entries, p at most TABLE_SLOTS - 2, then places the new one;
// a full table goes straight to its result without a walk.
// tick: a scan over the leading zero deltas, then one read and one result per
// expired entry, as long as the receiver takes each transfer at once.
// the result register lets the next item in while the last result still waits;
// a stalled receiver holds the block at the next result of a later item.
// reset empties the queue at once; ram contents need no clearing.
module delta_list_timer_queue_unit #(
  parameter int TABLE_SLOTS = dltq_pkg::TABLE_SLOTS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [dltq_pkg::KIND_W-1:0]   in_kind,
  input  logic [dltq_pkg::HANDLE_W-1:0] in_handle,
  input  logic [dltq_pkg::DELTA_W-1:0]  in_delay,
  input  logic                          in_blocked,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [dltq_pkg::STATUS_W-1:0] out_status,
  output logic [dltq_pkg::HANDLE_W-1:0] out_fired_handle,
  output logic                          out_last
);

  import dltq_pkg::*;

  localparam int IW = $clog2(TABLE_SLOTS);
  localparam logic [IW:0]   SLOTS    = TABLE_SLOTS[IW:0];
  localparam logic [IW-1:0] LAST_IDX = IW'(TABLE_SLOTS - 1);

  function automatic logic [IW-1:0] wrap_add(input logic [IW-1:0] a, input logic [IW-1:0] b);
    logic [IW:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= SLOTS) begin
      s = s - SLOTS;
    end
    return s[IW-1:0];
  endfunction

  function automatic logic [IW-1:0] wrap_dec(input logic [IW-1:0] a);
    return (a == '0) ? LAST_IDX : a - IW'(1);
  endfunction

  state_t              state_r, state_nxt;
  logic [IW-1:0]       head_r, head_nxt;
  logic [IW-1:0]       count_r, count_nxt;
  logic [IW-1:0]       lidx_r, lidx_nxt;
  logic [IW-1:0]       nfire_r, nfire_nxt;
  logic [IW-1:0]       eidx_r, eidx_nxt;
  logic [DELTA_W-1:0]  rem_r, rem_nxt;
  logic [HANDLE_W-1:0] hnd_r, hnd_nxt;
  logic                blk_r, blk_nxt;
  logic                dec_r, dec_nxt;
  status_t             resp_r, resp_nxt;

  logic                out_valid_r, out_valid_nxt;
  status_t             out_status_r, out_status_nxt;
  logic [HANDLE_W-1:0] out_handle_r, out_handle_nxt;
  logic                out_last_r, out_last_nxt;

  logic [IW-1:0]       rd_idx;
  logic [IW-1:0]       rd_addr;
  logic [ENTRY_W-1:0]  rd_data;
  logic [DELTA_W-1:0]  rd_delta;
  logic [HANDLE_W-1:0] rd_hnd;
  logic                wr_en;
  logic [IW-1:0]       wr_addr;
  logic [ENTRY_W-1:0]  wr_data;
  logic [IW-1:0]       cur_addr;
  logic [IW-1:0]       cur_m1;
  logic                live;
  logic                out_free;
  logic                e_last;

  dltq_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_SLOTS)
  ) u_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_data),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  assign rd_delta = rd_data[ENTRY_W-1:HANDLE_W];
  assign rd_hnd   = rd_data[HANDLE_W-1:0];
  assign cur_addr = wrap_add(head_r, lidx_r);
  assign cur_m1   = wrap_dec(cur_addr);
  assign live     = (lidx_r < count_r);
  assign out_free = !out_valid_r || out_ready;
  assign e_last   = (eidx_r == nfire_r - IW'(1));
  assign rd_addr  = wrap_add(head_r, rd_idx);

  assign in_ready         = (state_r == S_IDLE);
  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_fired_handle = out_handle_r;
  assign out_last         = out_last_r;

  always_comb begin
    unique case (state_r)
      S_WALK, S_SCAN: rd_idx = lidx_r + IW'(1);
      S_ERD, S_EOUT:  rd_idx = eidx_r;
      default:        rd_idx = '0;
    endcase
  end

  always_comb begin
    state_nxt      = state_r;
    head_nxt       = head_r;
    count_nxt      = count_r;
    lidx_nxt       = lidx_r;
    nfire_nxt      = nfire_r;
    eidx_nxt       = eidx_r;
    rem_nxt        = rem_r;
    hnd_nxt        = hnd_r;
    blk_nxt        = blk_r;
    dec_nxt        = dec_r;
    resp_nxt       = resp_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_status_nxt = out_status_r;
    out_handle_nxt = out_handle_r;
    out_last_nxt   = out_last_r;
    wr_en          = 1'b0;
    wr_addr        = cur_addr;
    wr_data        = rd_data;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          hnd_nxt  = in_handle;
          rem_nxt  = in_delay;
          blk_nxt  = in_blocked;
          lidx_nxt = '0;
          dec_nxt  = 1'b0;
          if (in_kind == KIND_INSERT) begin
            if (count_r == LAST_IDX) begin
              resp_nxt  = ST_FULL;
              state_nxt = S_RESP;
            end else begin
              state_nxt = S_WALK;
            end
          end else begin
            state_nxt = S_SCAN;
          end
        end
      end
      // earlier entries move one slot back as they are passed
      S_WALK: begin
        if (live && (rd_delta <= rem_r)) begin
          wr_en    = 1'b1;
          wr_addr  = cur_m1;
          wr_data  = rd_data;
          rem_nxt  = rem_r - rd_delta;
          lidx_nxt = lidx_r + IW'(1);
        end else begin
          if (live) begin
            wr_en   = 1'b1;
            wr_addr = cur_addr;
            wr_data = {rd_delta - rem_r, rd_hnd};
          end
          state_nxt = S_PLACE;
        end
      end
      S_PLACE: begin
        wr_en     = 1'b1;
        wr_addr   = cur_m1;
        wr_data   = {rem_r, hnd_r};
        head_nxt  = wrap_dec(head_r);
        count_nxt = count_r + IW'(1);
        resp_nxt  = ST_INSERTED;
        state_nxt = S_RESP;
      end
      // count leading zeros, decrementing the first positive delta on the way
      S_SCAN: begin
        if (live && (rd_delta == '0)) begin
          lidx_nxt = lidx_r + IW'(1);
        end else if (live && !dec_r && (rd_delta == DELTA_W'(1))) begin
          wr_en    = 1'b1;
          wr_data  = {{DELTA_W{1'b0}}, rd_hnd};
          dec_nxt  = 1'b1;
          lidx_nxt = lidx_r + IW'(1);
        end else begin
          if (live && !dec_r) begin
            wr_en   = 1'b1;
            wr_data = {rd_delta - DELTA_W'(1), rd_hnd};
          end
          nfire_nxt = lidx_r;
          eidx_nxt  = '0;
          if (blk_r || (lidx_r == '0)) begin
            state_nxt = S_IDLE;
          end else begin
            state_nxt = S_ERD;
          end
        end
      end
      S_ERD: begin
        state_nxt = S_EOUT;
      end
      S_EOUT: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = ST_EXPIRED;
          out_handle_nxt = rd_hnd;
          out_last_nxt   = e_last;
          eidx_nxt       = eidx_r + IW'(1);
          if (e_last) begin
            head_nxt  = wrap_add(head_r, nfire_r);
            count_nxt = count_r - nfire_r;
            state_nxt = S_IDLE;
          end else begin
            state_nxt = S_ERD;
          end
        end
      end
      S_RESP: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = resp_r;
          out_handle_nxt = '0;
          out_last_nxt   = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lidx_r       <= lidx_nxt;
    nfire_r      <= nfire_nxt;
    eidx_r       <= eidx_nxt;
    rem_r        <= rem_nxt;
    hnd_r        <= hnd_nxt;
    blk_r        <= blk_nxt;
    dec_r        <= dec_nxt;
    resp_r       <= resp_nxt;
    out_status_r <= out_status_nxt;
    out_handle_r <= out_handle_nxt;
    out_last_r   <= out_last_nxt;
  end

endmodule

### test/delta_list_timer_queue_unit_tb.sv
`timescale 1ns / 1ps

module delta_list_timer_queue_unit_tb;
  import dltq_pkg::*;

  localparam int LIVE_MAX       = TABLE_SLOTS_DEF - 1;
  localparam int RANDOM_ITEMS   = 170;
  localparam int CALM_ITEMS     = 40;
  localparam int LONG_HOLD      = 300;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DIRECTED_ROWS  = 20;
  localparam int BY_MODEL       = -1;

  typedef struct packed {
    status_t               status;
    logic [HANDLE_W-1:0]   fired_handle;
    logic                  last;
  } result_t;

  typedef struct packed {
    logic                kind;
    logic [HANDLE_W-1:0] handle;
    logic [DELTA_W-1:0]  delay;
    logic                blocked;
    int                  n_typed;
    result_t             typed;
  } script_row_t;

  localparam result_t NO_RESULT = '{ST_INSERTED, 16'h0000, 1'b0};
  localparam result_t INSERT_OK = '{ST_INSERTED, 16'h0000, 1'b1};

  logic                clk = 1'b0;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  logic [KIND_W-1:0]   in_kind;
  logic [HANDLE_W-1:0] in_handle;
  logic [DELTA_W-1:0]  in_delay;
  logic                in_blocked;
  logic                out_valid;
  logic                out_ready;
  logic [STATUS_W-1:0] out_status;
  logic [HANDLE_W-1:0] out_fired_handle;
  logic                out_last;

  // timer list as the block should hold it
  logic [DELTA_W-1:0]  slot_gap    [TABLE_SLOTS_DEF];
  logic [HANDLE_W-1:0] slot_handle [TABLE_SLOTS_DEF];
  int                  slots_used;

  result_t     step_results [$];
  result_t     due_results  [$];
  script_row_t script       [DIRECTED_ROWS];

  int errors;
  int work_items;
  int idle_cycles;
  bit calm_tail;
  bit long_hold_req;
  bit hold_done;

  delta_list_timer_queue_unit #(
    .TABLE_SLOTS(TABLE_SLOTS_DEF)
  ) i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_kind          (in_kind),
    .in_handle        (in_handle),
    .in_delay         (in_delay),
    .in_blocked       (in_blocked),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_status       (out_status),
    .out_fired_handle (out_fired_handle),
    .out_last         (out_last)
  );

  always #6 clk = ~clk;

  function automatic void advance_timers(logic kind, logic [HANDLE_W-1:0] hnd,
                                         logic [DELTA_W-1:0] dly, logic blk);
    int            pos;
    int            fired;
    logic [DELTA_W-1:0] rem;
    result_t       r;
    step_results.delete();
    if (kind == KIND_INSERT) begin
      r = INSERT_OK;
      if (slots_used >= LIVE_MAX) begin
        r.status = ST_FULL;
      end else begin
        rem = dly;
        pos = 0;
        while (pos < slots_used && slot_gap[pos] <= rem) begin
          rem = rem - slot_gap[pos];
          pos++;
        end
        if (pos < slots_used) slot_gap[pos] = slot_gap[pos] - rem;
        for (int j = slots_used; j > pos; j--) begin
          slot_gap[j]    = slot_gap[j-1];
          slot_handle[j] = slot_handle[j-1];
        end
        slot_gap[pos]    = rem;
        slot_handle[pos] = hnd;
        slots_used++;
      end
      step_results.push_back(r);
    end else if (slots_used > 0) begin
      pos = 0;
      while (pos < slots_used && slot_gap[pos] == 0) pos++;
      if (pos < slots_used) slot_gap[pos] = slot_gap[pos] - 1'b1;
      if (!blk) begin
        fired = 0;
        while (fired < slots_used && slot_gap[fired] == 0) fired++;
        for (int j = 0; j < fired; j++) begin
          r.status       = ST_EXPIRED;
          r.fired_handle = slot_handle[j];
          r.last         = (j == fired - 1);
          step_results.push_back(r);
        end
        for (int j = fired; j < slots_used; j++) begin
          slot_gap[j-fired]    = slot_gap[j];
          slot_handle[j-fired] = slot_handle[j];
        end
        slots_used -= fired;
      end
    end
  endfunction

  task automatic send_item(input logic kind, input logic [HANDLE_W-1:0] hnd,
                           input logic [DELTA_W-1:0] dly, input logic blk,
                           input int n_typed, input result_t typed);
    in_valid   <= 1'b1;
    in_kind    <= kind;
    in_handle  <= hnd;
    in_delay   <= dly;
    in_blocked <= blk;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    advance_timers(kind, hnd, dly, blk);
    if (n_typed == BY_MODEL) begin
      foreach (step_results[i]) due_results.push_back(step_results[i]);
    end else if (n_typed == 1) begin
      due_results.push_back(typed);
    end
    @(negedge clk);
    if (!calm_tail && $urandom_range(0, 99) < 20) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(negedge clk);
    end
  endtask

  task automatic offer(input logic kind, input logic [DELTA_W-1:0] dly, input logic blk);
    if (kind == KIND_INSERT || slots_used > 0) work_items++;
    send_item(kind, 16'($urandom_range(0, 65535)), dly, blk, BY_MODEL, NO_RESULT);
  endtask

  task automatic offer_mixed();
    logic [DELTA_W-1:0] dly;
    if ($urandom_range(0, 24) == 0) dly = 15'($urandom_range(0, 32767));
    else dly = 15'($urandom_range(0, 6));
    if ($urandom_range(0, 99) < 55) offer(KIND_INSERT, dly, 1'($urandom_range(0, 1)));
    else offer(KIND_TICK, dly, $urandom_range(0, 3) == 0);
  endtask

  task automatic fill_table();
    bit zero_fill;
    int n;
    zero_fill = $urandom_range(0, 1);
    n = LIVE_MAX - slots_used + $urandom_range(1, 3);
    if (!hold_done && !calm_tail) begin
      long_hold_req = 1'b1;
      hold_done     = 1'b1;
    end
    repeat (n) offer(KIND_INSERT, zero_fill ? 15'd0 : 15'($urandom_range(0, 3)),
                     1'($urandom_range(0, 1)));
    repeat ($urandom_range(2, 6)) offer(KIND_TICK, 15'($urandom_range(0, 32767)),
                                        $urandom_range(0, 4) == 0);
  endtask

  initial begin
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_kind    = KIND_TICK;
    in_handle  = '0;
    in_delay   = '0;
    in_blocked = 1'b0;
    errors     = 0;
    work_items = 0;
    calm_tail  = 1'b0;
    hold_done  = 1'b0;
    slots_used = 0;

    script = '{
      '{KIND_TICK,   16'h5A5A, 15'h7FFF, 1'b0, 0,        NO_RESULT},
      '{KIND_TICK,   16'h0000, 15'h0000, 1'b1, 0,        NO_RESULT},
      '{KIND_INSERT, 16'hFFFF, 15'h0000, 1'b1, 1,        INSERT_OK},
      '{KIND_INSERT, 16'h1234, 15'h0000, 1'b0, 1,        INSERT_OK},
      '{KIND_TICK,   16'h0000, 15'h0000, 1'b1, 0,        NO_RESULT},
      '{KIND_TICK,   16'h0000, 15'h0000, 1'b0, BY_MODEL, NO_RESULT},
      '{KIND_INSERT, 16'h0000, 15'h7FFF, 1'b0, 1,        INSERT_OK},
      '{KIND_INSERT, 16'h00A1, 15'd5,    1'b0, 1,        INSERT_OK},
      '{KIND_INSERT, 16'h00A2, 15'd5,    1'b0, 1,        INSERT_OK},
      '{KIND_INSERT, 16'h00A3, 15'd3,    1'b0, 1,        INSERT_OK},
      '{KIND_INSERT, 16'h00A4, 15'd1,    1'b0, 1,        INSERT_OK},
      '{KIND_TICK,   16'hFFFF, 15'h7FFF, 1'b0, BY_MODEL, NO_RESULT},
      '{KIND_TICK,   16'h0000, 15'h0000, 1'b1, 0,        NO_RESULT},
      '{KIND_TICK,   16'h0000, 15'h0000, 1'b0, BY_MODEL, NO_RESULT},
      '{KIND_TICK,   16'h0000, 15'h0000, 1'b1, 0,        NO_RESULT},
      '{KIND_TICK,   16'h0000, 15'h0000, 1'b1, 0,        NO_RESULT},
      '{KIND_TICK,   16'h0000, 15'h0000, 1'b1, 0,        NO_RESULT},
      '{KIND_INSERT, 16'h0B01, 15'h0000, 1'b0, 1,        INSERT_OK},
      '{KIND_TICK,   16'h0000, 15'h0000, 1'b0, BY_MODEL, NO_RESULT},
      '{KIND_TICK,   16'h0000, 15'h0000, 1'b0, 0,        NO_RESULT}
    };

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (script[i])
      send_item(script[i].kind, script[i].handle, script[i].delay, script[i].blocked,
                script[i].n_typed, script[i].typed);

    while (work_items < RANDOM_ITEMS) begin
      calm_tail = (work_items >= RANDOM_ITEMS - CALM_ITEMS);
      if ($urandom_range(0, 3) == 0 || !hold_done) fill_table();
      else repeat (8) offer_mixed();
    end
    in_valid <= 1'b0;

    while (due_results.size() != 0) @(posedge clk);
    repeat (TABLE_SLOTS_DEF + 8) @(posedge clk);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // receiver: short random stalls plus one long hold-off
  initial begin
    out_ready = 1'b0;
    long_hold_req = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
        out_ready <= 1'b1;
      end else if (!calm_tail && $urandom_range(0, 99) < 20) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 9)) @(negedge clk);
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : match_results
    result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (due_results.size() == 0) begin
        errors++;
        $display("%0t: result with nothing expected: status %0d handle %h last %b",
                 $time, out_status, out_fired_handle, out_last);
      end else begin
        want = due_results.pop_front();
        if (out_status !== want.status) begin
          errors++;
          $display("%0t: status expected %0d actual %0d", $time, want.status, out_status);
        end
        if (out_fired_handle !== want.fired_handle) begin
          errors++;
          $display("%0t: fired_handle expected %h actual %h",
                   $time, want.fired_handle, out_fired_handle);
        end
        if (out_last !== want.last) begin
          errors++;
          $display("%0t: last expected %b actual %b", $time, want.last, out_last);
        end
      end
    end
  end

  // count cycles without any transfer
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (rst_n && idle_cycles >= WATCHDOG_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

endmodule

### filelist.f
hdl/dltq_pkg.sv
hdl/dltq_ram.sv
hdl/delta_list_timer_queue_unit.sv
test/delta_list_timer_queue_unit_tb.sv
